>>> src/glyph_quad_layout_macros.svh
// Assertion macros for the glyph quad layout checker.
// Depends on nothing; the including module must declare i_clk and i_rst_n.
`ifndef GLYPH_QUAD_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_LAYOUT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define GQL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define GQL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/gql_pkg.sv
// Shared constants, codes and types of the glyph quad layout block.
// Depends on nothing; used by the interfaces, the divider, the top level and the checker.
package gql_pkg;

    // Glyph table geometry.
    localparam int GLYPH_ENTRIES = 256;
    localparam int GLYPH_AW      = $clog2(GLYPH_ENTRIES);
    localparam int MAX_QUADS     = 256;

    // Field widths.
    localparam int CP_W   = 21;
    localparam int AX_W   = 11;
    localparam int DIM_W  = 8;
    localparam int OFS_W  = 8;
    localparam int ADV_W  = 9;
    localparam int NUM_W  = AX_W + 1;
    localparam int SLOT_W = 11;
    localparam int POS_W  = 20;
    localparam int TEX_W  = 16;

    // Configuration register widths.
    localparam int LH_W       = 8;
    localparam int ATLAS_W    = 12;
    localparam int CAP_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Capacity compare widths.
    localparam int LIM_W  = $clog2(MAX_QUADS + 1);
    localparam int CAPX_W = (CAP_W > LIM_W) ? CAP_W : LIM_W;
    localparam int VLIM_W = ((CAPX_W + 2) > SLOT_W) ? (CAPX_W + 2) : SLOT_W;

    // Quad and divider sequencing.
    localparam int VERTS_PER_QUAD = 4;
    localparam int K_W            = $clog2(VERTS_PER_QUAD);
    localparam int DIV_STEPS      = 4;
    localparam int DIV_CYCLES     = TEX_W / DIV_STEPS;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    // Operation codes.
    localparam logic OP_GLYPH_WRITE = 1'b0;
    localparam logic OP_CHAR        = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_CAPACITY = 2'd3;

    // Register reset values.
    localparam logic [LH_W-1:0]    RST_LINE_HEIGHT   = 8'd32;
    localparam logic [ATLAS_W-1:0] RST_ATLAS_WIDTH   = 12'd256;
    localparam logic [ATLAS_W-1:0] RST_ATLAS_HEIGHT  = 12'd256;
    localparam logic [CAP_W-1:0]   RST_QUAD_CAPACITY = 9'd64;

    // Newline character code.
    localparam logic [CP_W-1:0] CP_NEWLINE = 21'd10;

    // One glyph table entry.
    typedef struct packed {
        logic [AX_W-1:0]         ax;
        logic [AX_W-1:0]         ay;
        logic [DIM_W-1:0]        w;
        logic [DIM_W-1:0]        h;
        logic signed [OFS_W-1:0] xo;
        logic signed [OFS_W-1:0] yo;
        logic signed [ADV_W-1:0] adv;
    } t_glyph;

    // Status of one texture coordinate divider.
    typedef struct packed {
        logic             done;
        logic [TEX_W-1:0] q;
    } t_div_res;

endpackage

>>> src/gql_if.sv
// Request and result channel interfaces of the glyph quad layout block.
// Depends on gql_pkg for the field widths.
interface gql_req_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [gql_pkg::CP_W-1:0]          code_point;
    logic [gql_pkg::AX_W-1:0]          glyph_atlas_x;
    logic [gql_pkg::AX_W-1:0]          glyph_atlas_y;
    logic [gql_pkg::DIM_W-1:0]         glyph_width;
    logic [gql_pkg::DIM_W-1:0]         glyph_height;
    logic signed [gql_pkg::OFS_W-1:0]  glyph_x_offset;
    logic signed [gql_pkg::OFS_W-1:0]  glyph_y_offset;
    logic signed [gql_pkg::ADV_W-1:0]  glyph_advance;
    logic                              last_of_text;

    modport source (
        output valid, opcode, code_point, glyph_atlas_x, glyph_atlas_y, glyph_width,
               glyph_height, glyph_x_offset, glyph_y_offset, glyph_advance, last_of_text,
        input  ready
    );
    modport sink (
        input  valid, opcode, code_point, glyph_atlas_x, glyph_atlas_y, glyph_width,
               glyph_height, glyph_x_offset, glyph_y_offset, glyph_advance, last_of_text,
        output ready
    );
endinterface

interface gql_res_if;
    logic                              valid;
    logic                              ready;
    logic [gql_pkg::SLOT_W-1:0]        vertex_slot;
    logic signed [gql_pkg::POS_W-1:0]  pos_x;
    logic signed [gql_pkg::POS_W-1:0]  pos_y;
    logic [gql_pkg::TEX_W-1:0]         tex_u;
    logic [gql_pkg::TEX_W-1:0]         tex_v;
    logic                              is_end_record;
    logic                              last_of_run;

    modport source (
        output valid, vertex_slot, pos_x, pos_y, tex_u, tex_v, is_end_record, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, vertex_slot, pos_x, pos_y, tex_u, tex_v, is_end_record, last_of_run,
        output ready
    );
endinterface

>>> src/gql_div.sv
// Texture coordinate divider: floor(num * 2^16 / den), saturated to 16 bits.
// Depends on gql_pkg; four restoring steps per cycle.
module gql_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gql_pkg::NUM_W-1:0]     i_num,
    input  logic [gql_pkg::ATLAS_W-1:0]   i_den,
    output gql_pkg::t_div_res             o_res
);
    localparam int NUM_W     = gql_pkg::NUM_W;
    localparam int ATLAS_W   = gql_pkg::ATLAS_W;
    localparam int TEX_W     = gql_pkg::TEX_W;
    localparam int DIV_CNT_W = gql_pkg::DIV_CNT_W;
    localparam int CMP_W     = (NUM_W > ATLAS_W) ? NUM_W : ATLAS_W;
    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(gql_pkg::DIV_CYCLES - 1);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ATLAS_W-1:0]   r_den;
    logic [ATLAS_W-1:0]   r_rem;
    logic [TEX_W-1:0]     r_q;
    logic                 r_sat;
    logic                 r_zero;
    logic [ATLAS_W-1:0]   n_rem;
    logic [TEX_W-1:0]     n_q;
    logic [ATLAS_W-1:0]   v_rem;
    logic [TEX_W-1:0]     v_q;
    logic [ATLAS_W:0]     v_t;

    // A few restoring steps per cycle; the remainder stays below the divisor.
    always_comb begin
        v_rem = r_rem;
        v_q   = r_q;
        v_t   = '0;
        for (int i = 0; i < gql_pkg::DIV_STEPS; i++) begin
            v_t = {v_rem, 1'b0};
            if (v_t >= {1'b0, r_den}) begin
                v_rem = ATLAS_W'(v_t - {1'b0, r_den});
                v_q   = {v_q[TEX_W-2:0], 1'b1};
            end else begin
                v_rem = ATLAS_W'(v_t);
                v_q   = {v_q[TEX_W-2:0], 1'b0};
            end
        end
        n_rem = v_rem;
        n_q   = v_q;
    end

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operands and partial quotient. A numerator not below the divisor saturates, but a zero numerator gives zero.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= ATLAS_W'(i_num);
            r_q    <= '0;
            r_sat  <= (CMP_W'(i_num) >= CMP_W'(i_den));
            r_zero <= (i_num == '0);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_res.done = r_busy && (r_cnt == CNT_LAST);
    assign o_res.q    = r_zero ? '0 : (r_sat ? '1 : r_q);

endmodule

>>> src/glyph_quad_layout.sv
// Top level of the glyph quad layout block: glyph table, cursor and vertex sequencer.
// Depends on gql_pkg, gql_req_if, gql_res_if and gql_div.
//
// Usage: requests arrive on i_req (valid/ready). A glyph write request stores one
// glyph in the table in the cycle it is accepted (a code point outside the table
// is not stored) and is ready again in the next cycle. A character request reads
// the table, runs the four texture coordinate dividers (four quotient bits each
// per cycle) and then loads its four vertices into the output register, one per
// cycle while o_res takes them. A newline, or a character with no buffer room,
// skips the dividers; a request marked last then adds an end record. i_req.ready
// is high only while the sequencer is idle; the output register keeps the last
// result until it is taken, so the next request can be accepted meanwhile. When
// o_res stalls, the sequencer waits with the pending vertex. The user must see
// that the configuration port (i_cfg_we, i_cfg_index, i_cfg_data) is written
// only while idle; the block itself does not enforce this. Reset (i_rst_n low,
// synchronous) clears the table valid bits so every glyph reads as zero, clears
// cursor and vertex count, and loads the register defaults.
module glyph_quad_layout (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gql_req_if.sink                           i_req,
    gql_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [gql_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gql_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int CP_W     = gql_pkg::CP_W;
    localparam int GLYPH_AW = gql_pkg::GLYPH_AW;
    localparam int NUM_W    = gql_pkg::NUM_W;
    localparam int SLOT_W   = gql_pkg::SLOT_W;
    localparam int POS_W    = gql_pkg::POS_W;
    localparam int PX_W     = POS_W + 2;
    localparam int TEX_W    = gql_pkg::TEX_W;
    localparam int CAPX_W   = gql_pkg::CAPX_W;
    localparam int VLIM_W   = gql_pkg::VLIM_W;
    localparam int K_W      = gql_pkg::K_W;
    localparam logic [K_W-1:0] K_LAST = K_W'(gql_pkg::VERTS_PER_QUAD - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DIV  = 5'b00100,
        S_EMIT = 5'b01000,
        S_END  = 5'b10000
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic                    is_end;
        logic                    last_run;
    } t_out;

    // Saturate an extended position to the signed output range.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PX_W-1:0] v);
        if (v[PX_W-1:POS_W-1] == '0 || v[PX_W-1:POS_W-1] == '1) begin
            sat_pos = v[POS_W-1:0];
        end else if (v[PX_W-1]) begin
            sat_pos = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            sat_pos = {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

    // Glyph table storage.
    gql_pkg::t_glyph                     r_table [gql_pkg::GLYPH_ENTRIES];
    logic [gql_pkg::GLYPH_ENTRIES-1:0]   r_table_vld;
    gql_pkg::t_glyph                     r_rd_data;
    logic                                r_rd_hit;

    // Configuration registers.
    logic [gql_pkg::LH_W-1:0]    r_line_height;
    logic [gql_pkg::ATLAS_W-1:0] r_atlas_width;
    logic [gql_pkg::ATLAS_W-1:0] r_atlas_height;
    logic [gql_pkg::CAP_W-1:0]   r_quad_cap;

    // Sequencer state.
    t_state                  r_state, n_state;
    logic [K_W-1:0]          r_k, n_k;
    logic signed [POS_W-1:0] r_cursor_x, n_cursor_x;
    logic signed [POS_W-1:0] r_cursor_y, n_cursor_y;
    logic [SLOT_W-1:0]       r_vused, n_vused;
    logic                    r_newline;
    logic                    r_last;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out, n_out;

    logic                    w_accept;
    logic                    w_in_table;
    logic [GLYPH_AW-1:0]     w_addr;
    logic                    w_wr_en;
    logic                    w_rd_en;
    gql_pkg::t_glyph         w_wr_data;
    gql_pkg::t_glyph         w_glyph;
    logic [CAPX_W-1:0]       w_cap;
    logic [VLIM_W-1:0]       w_vlim;
    logic                    w_room;
    logic                    w_div_start;
    logic                    w_div_done;
    logic                    w_slot_free;
    logic                    w_cx;
    logic                    w_cy;
    logic [gql_pkg::DIM_W-1:0] w_dx;
    logic [gql_pkg::DIM_W-1:0] w_dy;
    logic signed [PX_W-1:0]  w_px;
    logic signed [PX_W-1:0]  w_py;
    logic signed [POS_W-1:0] w_cx_adv;
    logic signed [POS_W-1:0] w_cy_nl;
    gql_pkg::t_div_res       w_du0, w_du1, w_dv0, w_dv1;
    t_out                    w_vert;
    t_out                    w_endrec;

    // Request decode.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_table  = i_req.code_point < CP_W'(gql_pkg::GLYPH_ENTRIES);
    assign w_addr      = i_req.code_point[GLYPH_AW-1:0];
    assign w_wr_en     = w_accept && (i_req.opcode == gql_pkg::OP_GLYPH_WRITE) && w_in_table;
    assign w_rd_en     = w_accept && (i_req.opcode == gql_pkg::OP_CHAR);

    assign w_wr_data.ax  = i_req.glyph_atlas_x;
    assign w_wr_data.ay  = i_req.glyph_atlas_y;
    assign w_wr_data.w   = i_req.glyph_width;
    assign w_wr_data.h   = i_req.glyph_height;
    assign w_wr_data.xo  = i_req.glyph_x_offset;
    assign w_wr_data.yo  = i_req.glyph_y_offset;
    assign w_wr_data.adv = i_req.glyph_advance;

    // Table memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[w_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_table[w_addr];
        end
    end

    // Entry valid bits; an unwritten or out-of-range entry reads as zero metrics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_vld <= '0;
            r_rd_hit    <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_table_vld[w_addr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_hit <= w_in_table && r_table_vld[w_addr];
            end
        end
    end

    assign w_glyph = r_rd_hit ? r_rd_data : '0;

    // Request attributes held for the sequencer.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_newline <= (i_req.code_point == gql_pkg::CP_NEWLINE);
            r_last    <= i_req.last_of_text;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_height  <= gql_pkg::RST_LINE_HEIGHT;
            r_atlas_width  <= gql_pkg::RST_ATLAS_WIDTH;
            r_atlas_height <= gql_pkg::RST_ATLAS_HEIGHT;
            r_quad_cap     <= gql_pkg::RST_QUAD_CAPACITY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gql_pkg::CFG_LINE_HEIGHT: begin
                    r_line_height <= i_cfg_data[gql_pkg::LH_W-1:0];
                end
                gql_pkg::CFG_ATLAS_WIDTH: begin
                    r_atlas_width <= i_cfg_data[gql_pkg::ATLAS_W-1:0];
                end
                gql_pkg::CFG_ATLAS_HEIGHT: begin
                    r_atlas_height <= i_cfg_data[gql_pkg::ATLAS_W-1:0];
                end
                gql_pkg::CFG_QUAD_CAPACITY: begin
                    r_quad_cap <= i_cfg_data[gql_pkg::CAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Buffer room: vertex count below four times the effective quad capacity.
    assign w_cap  = (CAPX_W'(r_quad_cap) < CAPX_W'(gql_pkg::MAX_QUADS))
                    ? CAPX_W'(r_quad_cap) : CAPX_W'(gql_pkg::MAX_QUADS);
    assign w_vlim = VLIM_W'(w_cap) << 2;
    assign w_room = VLIM_W'(r_vused) < w_vlim;

    // Texture coordinate dividers, one per distinct corner coordinate.
    assign w_div_start = (r_state == S_READ) && w_room && !r_newline;

    gql_div u_div_u0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (NUM_W'(w_glyph.ax)),
        .i_den   (r_atlas_width),
        .o_res   (w_du0)
    );

    gql_div u_div_u1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (NUM_W'(w_glyph.ax) + NUM_W'(w_glyph.w)),
        .i_den   (r_atlas_width),
        .o_res   (w_du1)
    );

    gql_div u_div_v0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (NUM_W'(w_glyph.ay) + NUM_W'(w_glyph.h)),
        .i_den   (r_atlas_height),
        .o_res   (w_dv0)
    );

    gql_div u_div_v1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (NUM_W'(w_glyph.ay)),
        .i_den   (r_atlas_height),
        .o_res   (w_dv1)
    );

    assign w_div_done = w_du0.done && w_du1.done && w_dv0.done && w_dv1.done;

    // Corner vertex k: bit 0 selects the right edge, bit 1 the top row.
    assign w_cx = r_k[0];
    assign w_cy = r_k[1];
    assign w_dx = w_cx ? w_glyph.w : '0;
    assign w_dy = w_cy ? '0 : w_glyph.h;
    assign w_px = PX_W'(r_cursor_x) + PX_W'(signed'({1'b0, w_dx})) + PX_W'(w_glyph.xo);
    assign w_py = PX_W'(r_cursor_y) + PX_W'(signed'({1'b0, w_dy})) + PX_W'(w_glyph.yo);

    assign w_vert.slot     = r_vused + SLOT_W'({w_cx, w_cy});
    assign w_vert.pos_x    = sat_pos(w_px);
    assign w_vert.pos_y    = sat_pos(w_py);
    assign w_vert.tex_u    = w_cx ? w_du1.q : w_du0.q;
    assign w_vert.tex_v    = w_cy ? w_dv1.q : w_dv0.q;
    assign w_vert.is_end   = 1'b0;
    assign w_vert.last_run = (r_k == K_LAST) && !r_last;

    assign w_endrec.slot     = r_vused;
    assign w_endrec.pos_x    = '0;
    assign w_endrec.pos_y    = '0;
    assign w_endrec.tex_u    = '0;
    assign w_endrec.tex_v    = '0;
    assign w_endrec.is_end   = 1'b1;
    assign w_endrec.last_run = 1'b1;

    // Cursor steps.
    assign w_cx_adv = sat_pos(PX_W'(r_cursor_x) + PX_W'(w_glyph.adv));
    assign w_cy_nl  = sat_pos(PX_W'(r_cursor_y) + PX_W'(signed'({1'b0, r_line_height})));

    assign w_slot_free = !r_out_valid || o_res.ready;

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_vused     = r_vused;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_rd_en) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_room && !r_newline) begin
                    n_state = S_DIV;
                end else begin
                    if (w_room) begin
                        n_cursor_x = '0;
                        n_cursor_y = w_cy_nl;
                    end
                    n_state = r_last ? S_END : S_IDLE;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_EMIT;
                    n_k     = '0;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = w_vert;
                    n_k         = r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        n_vused    = r_vused + SLOT_W'(gql_pkg::VERTS_PER_QUAD);
                        n_cursor_x = w_cx_adv;
                        n_state    = r_last ? S_END : S_IDLE;
                    end
                end
            end
            S_END: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = w_endrec;
                    n_vused     = '0;
                    n_cursor_x  = '0;
                    n_cursor_y  = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_vused     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_vused     <= n_vused;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.vertex_slot   = r_out.slot;
    assign o_res.pos_x         = r_out.pos_x;
    assign o_res.pos_y         = r_out.pos_y;
    assign o_res.tex_u         = r_out.tex_u;
    assign o_res.tex_v         = r_out.tex_v;
    assign o_res.is_end_record = r_out.is_end;
    assign o_res.last_of_run   = r_out.last_run;

endmodule

>>> src/gql_checker.sv
// Port-level assertions for glyph_quad_layout and the bind that attaches them.
// Depends on gql_pkg and glyph_quad_layout_macros.svh.
`include "glyph_quad_layout_macros.svh"

module gql_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_req_opcode,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic [gql_pkg::SLOT_W-1:0]        i_res_slot,
    input logic signed [gql_pkg::POS_W-1:0]  i_res_pos_x,
    input logic signed [gql_pkg::POS_W-1:0]  i_res_pos_y,
    input logic [gql_pkg::TEX_W-1:0]         i_res_tex_u,
    input logic [gql_pkg::TEX_W-1:0]         i_res_tex_v,
    input logic                              i_res_end,
    input logic                              i_res_last
);

    // An end record always closes the run of its request.
    `GQL_ASSERT_SAME(a_end_is_last, i_res_valid && i_res_end, i_res_last, "end record without last_of_run")

    // An end record carries only the vertex count.
    `GQL_ASSERT_SAME(a_end_zero, i_res_valid && i_res_end, i_res_pos_x == 0 && i_res_pos_y == 0 && i_res_tex_u == 0 && i_res_tex_v == 0, "end record with nonzero vertex data")

    // A character request keeps the block busy for at least the table read.
    `GQL_ASSERT_NEXT(a_char_busy, i_req_valid && i_req_ready && i_req_opcode == gql_pkg::OP_CHAR, !i_req_ready, "ready right after a character request")

    // A stalled result stays valid with the same slot and last_of_run.
    `GQL_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_slot) && $stable(i_res_last), "stalled result changed")

endmodule

bind glyph_quad_layout gql_checker u_gql_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_opcode (i_req.opcode),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_slot   (o_res.vertex_slot),
    .i_res_pos_x  (o_res.pos_x),
    .i_res_pos_y  (o_res.pos_y),
    .i_res_tex_u  (o_res.tex_u),
    .i_res_tex_v  (o_res.tex_v),
    .i_res_end    (o_res.is_end_record),
    .i_res_last   (o_res.last_of_run)
);

>>> sim/glyph_quad_layout_tb.sv
// Self-checking testbench for glyph_quad_layout: glyph writes, quad layout, newlines,
// end records, full buffer and saturation, under random idling and back-pressure.
// Depends on gql_pkg, gql_req_if and gql_res_if from the RTL source folder.
module glyph_quad_layout_tb;
    import gql_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 60;
    localparam int MAX_GAP        = 12;
    localparam int MAX_REPORTS    = 40;

    // One request as queued for the driver.
    typedef struct {
        logic             opcode;
        logic [CP_W-1:0]  code_point;
        t_glyph           glyph;
        logic             last_of_text;
        int               gap;
        bit               drain;
    } text_req_t;

    // One result as seen on the result channel.
    typedef struct packed {
        logic [SLOT_W-1:0]        vertex_slot;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [TEX_W-1:0]         tex_u;
        logic [TEX_W-1:0]         tex_v;
        logic                     is_end_record;
        logic                     last_of_run;
    } quad_vtx_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gql_req_if req_if ();
    gql_res_if res_if ();

    glyph_quad_layout dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Layout state mirrored by the testbench.
    t_glyph    font_tbl [GLYPH_ENTRIES];
    longint    pen_x;
    longint    pen_y;
    int        verts_used;
    int        line_step;
    int        atlas_w;
    int        atlas_h;
    int        quad_cap;

    text_req_t text_q [$];
    quad_vtx_t vertex_q [$];
    int        font_codes [$];
    text_req_t on_bus;

    bit        tx_idle_on;
    bit        rx_idle_on;
    bit        hold_armed;
    int        tx_wait;
    int        rx_wait;
    int        rx_hold;
    int        idle_cycles;

    int        n_errors;
    int        n_reqs;
    int        n_writes;
    int        n_vertices;
    int        n_ends;
    int        n_settings;

    quad_vtx_t rx_got;
    quad_vtx_t rx_want;
    bit        rx_bad;

    // Clock with a 10 unit period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sat_pos(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // Atlas coordinate as unsigned 0.16, truncated and saturated.
    function automatic logic [TEX_W-1:0] tex_coord(longint num, longint div);
        longint q;
        if (div == 0) begin
            q = (num != 0) ? 65535 : 0;
        end else begin
            q = (num << 16) / div;
            if (q > 65535) q = 65535;
        end
        return q[TEX_W-1:0];
    endfunction

    // Computes the results of one accepted request and updates the layout state.
    task automatic lay_out(input text_req_t r);
        t_glyph    g;
        quad_vtx_t v;
        quad_vtx_t run [$];
        int        cap;
        int        cx;
        int        cy;
        if (r.opcode == OP_GLYPH_WRITE) begin
            if (r.code_point < GLYPH_ENTRIES) font_tbl[r.code_point[GLYPH_AW-1:0]] = r.glyph;
            n_writes++;
        end else begin
            cap = (quad_cap < MAX_QUADS) ? quad_cap : MAX_QUADS;
            g = (r.code_point < GLYPH_ENTRIES) ? font_tbl[r.code_point[GLYPH_AW-1:0]] : '0;
            if (verts_used < cap * VERTS_PER_QUAD) begin
                if (r.code_point == CP_NEWLINE) begin
                    pen_x = 0;
                    pen_y = sat_pos(pen_y + line_step);
                end else begin
                    // Corners go out as bottom-left, bottom-right, top-left, top-right.
                    for (int k = 0; k < VERTS_PER_QUAD; k++) begin
                        cy = k >> 1;
                        cx = k & 1;
                        v = '0;
                        v.vertex_slot = verts_used + cy + 2 * cx;
                        v.pos_x = sat_pos(pen_x + cx * longint'(g.w)
                                          + longint'($signed(g.xo)));
                        v.pos_y = sat_pos(pen_y + (1 - cy) * longint'(g.h)
                                          + longint'($signed(g.yo)));
                        v.tex_u = tex_coord(cx * longint'(g.w) + longint'(g.ax), atlas_w);
                        v.tex_v = tex_coord((1 - cy) * longint'(g.h) + longint'(g.ay),
                                            atlas_h);
                        run.push_back(v);
                    end
                    verts_used = (verts_used + VERTS_PER_QUAD) % (1 << SLOT_W);
                    pen_x = sat_pos(pen_x + longint'($signed(g.adv)));
                end
            end
            if (r.last_of_text) begin
                v = '0;
                v.vertex_slot = verts_used;
                v.is_end_record = 1'b1;
                run.push_back(v);
                verts_used = 0;
                pen_x = 0;
                pen_y = 0;
            end
            if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[i]) vertex_q.push_back(run[i]);
        end
    endtask

    function automatic bit field_ok(string nm, longint want, longint got);
        if (want == got) return 1'b1;
        if (n_errors < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
        return 1'b0;
    endfunction

    function automatic t_glyph mk_glyph(int ax, int ay, int w, int h, int xo, int yo,
                                        int adv);
        t_glyph g;
        g.ax  = ax[AX_W-1:0];
        g.ay  = ay[AX_W-1:0];
        g.w   = w[DIM_W-1:0];
        g.h   = h[DIM_W-1:0];
        g.xo  = xo[OFS_W-1:0];
        g.yo  = yo[OFS_W-1:0];
        g.adv = adv[ADV_W-1:0];
        return g;
    endfunction

    function automatic t_glyph rand_glyph();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_glyph)-1:0];
    endfunction

    function automatic void queue_req(logic op, int cp, logic last, t_glyph g, bit drain);
        text_req_t r;
        r.opcode       = op;
        r.code_point   = cp[CP_W-1:0];
        r.glyph        = g;
        r.last_of_text = last;
        r.drain        = drain;
        r.gap          = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        text_q.push_back(r);
    endfunction

    function automatic void queue_char(int cp, logic last, bit drain = 1'b0);
        queue_req(OP_CHAR, cp, last, rand_glyph(), drain);
    endfunction

    function automatic void queue_glyph(int cp, t_glyph g, logic last = 1'b0);
        queue_req(OP_GLYPH_WRITE, cp, last, g, 1'b0);
        if (cp < GLYPH_ENTRIES) font_codes.push_back(cp);
    endfunction

    function automatic int font_pick();
        return font_codes[$urandom_range(0, font_codes.size() - 1)];
    endfunction

    function automatic int far_code();
        return $urandom_range(GLYPH_ENTRIES, (1 << CP_W) - 1);
    endfunction

    function automatic int pick_atlas();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 4095;
            2: return 2048;
            3: return 1;
            default: return $urandom_range(1, 2048);
        endcase
    endfunction

    // Mostly well-formed texts over written glyphs, with some noise mixed in.
    function automatic void queue_random_text(int count);
        int  pick;
        bit  last;
        bit  drain;
        for (int i = 0; i < count; i++) begin
            pick  = $urandom_range(0, 99);
            last  = ($urandom_range(0, 9) == 0);
            drain = ($urandom_range(0, 19) == 0);
            if (pick < 10)
                queue_glyph(($urandom_range(0, 7) == 0) ? far_code() : $urandom_range(0, 255),
                            rand_glyph(), last);
            else if (pick < 24)
                queue_char(CP_NEWLINE, last, drain);
            else if (pick < 30)
                queue_char(far_code(), last, drain);
            else if (pick < 34)
                queue_char($urandom_range(0, 255), last, drain);
            else
                queue_char(font_pick(), last, drain);
        end
    endfunction

    // Register write; the mirrored copy changes at the edge that drives cfg_we, before the register itself.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_LINE_HEIGHT:   line_step = val[LH_W-1:0];
            CFG_ATLAS_WIDTH:   atlas_w   = val[ATLAS_W-1:0];
            CFG_ATLAS_HEIGHT:  atlas_h   = val[ATLAS_W-1:0];
            CFG_QUAD_CAPACITY: quad_cap  = val[CAP_W-1:0];
            default: ;
        endcase
        n_settings++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(int lh, int aw, int ah, int cap);
        set_reg(CFG_LINE_HEIGHT, lh);
        set_reg(CFG_ATLAS_WIDTH, aw);
        set_reg(CFG_ATLAS_HEIGHT, ah);
        set_reg(CFG_QUAD_CAPACITY, cap);
    endtask

    // Waits until every request is taken and every result has come, then lets
    // requests without results finish inside the block.
    task automatic wait_idle();
        while (text_q.size() != 0 || vertex_q.size() != 0 || req_if.valid)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: predicts on acceptance, then presents the next request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            tx_wait      <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                lay_out(on_bus);
                n_reqs++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (text_q.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (tx_wait < text_q[0].gap) begin
                    tx_wait      <= tx_wait + 1;
                    req_if.valid <= 1'b0;
                end else if (text_q[0].drain && vertex_q.size() != 0) begin
                    req_if.valid <= 1'b0;
                end else begin
                    on_bus = text_q.pop_front();
                    req_if.opcode         <= on_bus.opcode;
                    req_if.code_point     <= on_bus.code_point;
                    req_if.glyph_atlas_x  <= on_bus.glyph.ax;
                    req_if.glyph_atlas_y  <= on_bus.glyph.ay;
                    req_if.glyph_width    <= on_bus.glyph.w;
                    req_if.glyph_height   <= on_bus.glyph.h;
                    req_if.glyph_x_offset <= on_bus.glyph.xo;
                    req_if.glyph_y_offset <= on_bus.glyph.yo;
                    req_if.glyph_advance  <= on_bus.glyph.adv;
                    req_if.last_of_text   <= on_bus.last_of_text;
                    req_if.valid          <= 1'b1;
                    tx_wait               <= 0;
                end
            end
        end
    end

    // Result monitor: checks each taken result and paces the ready signal.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_wait      <= 0;
            rx_hold      <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                rx_got = '{res_if.vertex_slot, res_if.pos_x, res_if.pos_y, res_if.tex_u,
                           res_if.tex_v, res_if.is_end_record, res_if.last_of_run};
                if (vertex_q.size() == 0) begin
                    if (n_errors < MAX_REPORTS)
                        $display("%0t: result with nothing expected, actual slot %0d end %0b",
                                 $time, rx_got.vertex_slot, rx_got.is_end_record);
                    n_errors++;
                end else begin
                    rx_want = vertex_q.pop_front();
                    rx_bad = 1'b0;
                    rx_bad |= !field_ok("vertex_slot", rx_want.vertex_slot, rx_got.vertex_slot);
                    rx_bad |= !field_ok("pos_x", $signed(rx_want.pos_x), $signed(rx_got.pos_x));
                    rx_bad |= !field_ok("pos_y", $signed(rx_want.pos_y), $signed(rx_got.pos_y));
                    rx_bad |= !field_ok("tex_u", rx_want.tex_u, rx_got.tex_u);
                    rx_bad |= !field_ok("tex_v", rx_want.tex_v, rx_got.tex_v);
                    rx_bad |= !field_ok("is_end_record", rx_want.is_end_record,
                                        rx_got.is_end_record);
                    rx_bad |= !field_ok("last_of_run", rx_want.last_of_run,
                                        rx_got.last_of_run);
                    if (rx_bad) n_errors++;
                    if (rx_want.is_end_record) n_ends++;
                    else n_vertices++;
                end
            end
            if (rx_hold > 0) begin
                rx_hold      <= rx_hold - 1;
                res_if.ready <= (rx_hold == 1);
            end else if (res_if.valid && res_if.ready) begin
                if (hold_armed) begin
                    hold_armed   <= 1'b0;
                    rx_hold      <= LONG_HOLD;
                    res_if.ready <= 1'b0;
                end else begin
                    rx_wait      <= rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                    res_if.ready <= !rx_idle_on;
                end
            end else if (rx_wait > 0) begin
                rx_wait      <= rx_wait - 1;
                res_if.ready <= (rx_wait == 1);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no request and no result taken.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, vertex_q.size());
            $display("[glyph_quad_layout] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_LINE_HEIGHT;
        cfg_data              = '0;
        req_if.valid          = 1'b0;
        req_if.opcode         = OP_GLYPH_WRITE;
        req_if.code_point     = '0;
        req_if.glyph_atlas_x  = '0;
        req_if.glyph_atlas_y  = '0;
        req_if.glyph_width    = '0;
        req_if.glyph_height   = '0;
        req_if.glyph_x_offset = '0;
        req_if.glyph_y_offset = '0;
        req_if.glyph_advance  = '0;
        req_if.last_of_text   = 1'b0;
        res_if.ready          = 1'b0;
        foreach (font_tbl[i]) font_tbl[i] = '0;
        pen_x      = 0;
        pen_y      = 0;
        verts_used = 0;
        line_step  = RST_LINE_HEIGHT;
        atlas_w    = RST_ATLAS_WIDTH;
        atlas_h    = RST_ATLAS_HEIGHT;
        quad_cap   = RST_QUAD_CAPACITY;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_armed = 1'b0;
        idle_cycles = 0;
        n_errors = 0;
        n_reqs = 0;
        n_writes = 0;
        n_vertices = 0;
        n_ends = 0;
        n_settings = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset table, field extremes, codes outside the table, newline.
        queue_char(65, 1'b0);
        queue_glyph(65, mk_glyph(2047, 2047, 255, 255, -128, 127, 255));
        queue_glyph(66, mk_glyph(0, 0, 0, 0, 127, -128, -256));
        queue_req(OP_GLYPH_WRITE, 256, 1'b1, rand_glyph(), 1'b0);
        queue_req(OP_GLYPH_WRITE, (1 << CP_W) - 1, 1'b0, rand_glyph(), 1'b0);
        queue_char(65, 1'b0);
        queue_char(66, 1'b0);
        queue_char(CP_NEWLINE, 1'b0);
        queue_char(65, 1'b0);
        queue_char((1 << CP_W) - 1, 1'b0);
        queue_char(256, 1'b0);
        queue_char(255, 1'b0);
        queue_req(OP_GLYPH_WRITE, CP_NEWLINE, 1'b0, rand_glyph(), 1'b0);
        queue_char(66, 1'b1);
        queue_char(CP_NEWLINE, 1'b1);
        queue_glyph(0, rand_glyph());
        queue_char(0, 1'b1);
        wait_idle();

        // Capacity of one quad: later characters and newlines are dropped.
        set_all(255, 1, 4095, 1);
        queue_char(65, 1'b0);
        queue_char(66, 1'b0);
        queue_char(CP_NEWLINE, 1'b0);
        queue_char(65, 1'b1);
        wait_idle();

        // Zero atlas size, then zero capacity.
        set_all(0, 0, 0, 2);
        queue_char(66, 1'b0);
        queue_char(CP_NEWLINE, 1'b0);
        queue_char(65, 1'b1);
        wait_idle();
        set_reg(CFG_QUAD_CAPACITY, 0);
        queue_char(65, 1'b1);
        queue_char(CP_NEWLINE, 1'b1);
        wait_idle();

        // Back-pressure: the receiver holds off while requests keep coming,
        // then the sender pauses until all results are in.
        set_all(RST_LINE_HEIGHT, RST_ATLAS_WIDTH, RST_ATLAS_HEIGHT, RST_QUAD_CAPACITY);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_armed = 1'b1;
        for (int i = 0; i < 12; i++) queue_char(font_pick(), i == 11);
        queue_char(font_pick(), 1'b0, 1'b1);
        for (int i = 0; i < 3; i++) queue_char(font_pick(), i == 2);
        wait_idle();

        // Cursor saturation and a full buffer at the largest capacity.
        set_all(255, 2048, 2048, 511);
        for (int i = 0; i < 2060; i++) queue_char(CP_NEWLINE, 1'b0);
        queue_char(65, 1'b0);
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        for (int i = 0; i < MAX_QUADS; i++) queue_char(font_pick(), 1'b0);
        queue_char(66, 1'b0);
        queue_char(CP_NEWLINE, 1'b0);
        queue_char(65, 1'b1);
        wait_idle();

        // Random texts under several settings, one stretch per side without idling.
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 1);
            set_all($urandom_range(0, 255), pick_atlas(), pick_atlas(),
                    (ph == 3) ? 511 : $urandom_range(0, 16));
            if (ph == 0)
                for (int i = 0; i < 12; i++) queue_glyph($urandom_range(0, 255), rand_glyph());
            queue_random_text(50);
            wait_idle();
        end

        $display("Checked %0d requests (%0d glyph writes): %0d vertices, %0d end records,",
                 n_reqs, n_writes, n_vertices, n_ends);
        $display("across %0d register writes with random and back-pressured handshakes.",
                 n_settings);
        if (n_errors == 0 && vertex_q.size() == 0) begin
            $display("[glyph_quad_layout] OK");
        end else begin
            $display("%0d failing results, %0d results never seen", n_errors, vertex_q.size());
            $display("[glyph_quad_layout] ERROR");
        end
        $finish;
    end

endmodule

>>> glyph_quad_layout.f
+incdir+src
src/gql_pkg.sv
src/gql_if.sv
src/gql_div.sv
src/glyph_quad_layout.sv
src/gql_checker.sv
sim/glyph_quad_layout_tb.sv
